FILE: src/lzfd_pkg.sv
// shared types and constants for the flag-byte lzss decompressor
package lzfd_pkg;

  // token field widths
  localparam int DIST_W = 14;
  localparam int LEN_W  = 4;

  // end-of-payload status codes
  localparam logic [2:0] ST_NONE  = 3'd0;
  localparam logic [2:0] ST_OK    = 3'd1;
  localparam logic [2:0] ST_SHORT = 3'd2;
  localparam logic [2:0] ST_DIST  = 3'd3;
  localparam logic [2:0] ST_OVER  = 3'd4;
  localparam logic [2:0] ST_TRAIL = 3'd5;

  // input kind codes
  localparam logic KIND_BYTE = 1'b0;
  localparam logic KIND_END  = 1'b1;

  // token constants
  localparam logic [2:0] MIN_MATCH = 3'd3;

  typedef struct packed {
    logic       kind;
    logic [7:0] data_byte;
  } in_word_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic [2:0] status;
    logic       last;
  } out_word_t;

  // work handed from the parser to the copy engine
  typedef enum logic [1:0] {
    CMD_LIT,
    CMD_MATCH,
    CMD_END
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t         kind;
    logic [7:0]        data;
    logic [DIST_W-1:0] distance;
    logic [LEN_W-1:0]  len;
    logic [2:0]        status;
  } cmd_t;

endpackage

FILE: src/lzfd_front.sv
// input parser: flag tracking, token decode, size and distance checks
module lzfd_front import lzfd_pkg::*; #(
  parameter int SIZE_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_word_t    in_word,
  input  logic        cfg_valid,
  input  logic [31:0] cfg_data,
  output logic        push,
  output cmd_t        push_cmd,
  input  logic        q_full
);

  typedef enum logic [1:0] {
    PH_FLAG,
    PH_ITEM,
    PH_HIGH
  } phase_t;

  phase_t                 phase;
  logic [7:0]             flag_bits;
  logic [2:0]             flag_pos;
  logic [7:0]             token_low;
  logic [SIZE_BITS-1:0]   produced;
  logic [2:0]             error_code;
  logic [31:0]            byte_target;

  logic                   accept;
  logic [SIZE_BITS-1:0]   limit;
  logic [SIZE_BITS-1:0]   remaining;
  logic [DIST_W-1:0]      distance;
  logic [LEN_W-1:0]       len;
  logic [2:0]             flag_pos_inc;
  logic                   cur_flag;
  logic [2:0]             end_status;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  // decode of the current byte as a token high byte, the current flag bit and the end status
  always_comb begin
    limit        = SIZE_BITS'(byte_target);
    remaining    = limit - produced;
    distance     = {1'b0, in_word.data_byte[7:3], token_low} + DIST_W'(1);
    len          = LEN_W'(in_word.data_byte[2:0]) + LEN_W'(MIN_MATCH);
    flag_pos_inc = flag_pos + 3'd1;
    cur_flag     = flag_bits[flag_pos];
    if (error_code != ST_NONE) begin
      end_status = error_code;
    end else if (produced < limit) begin
      end_status = ST_SHORT;
    end else begin
      end_status = ST_OK;
    end
  end

  // command generation for an accepted word
  always_comb begin
    push              = 1'b0;
    push_cmd.kind     = CMD_LIT;
    push_cmd.data     = in_word.data_byte;
    push_cmd.distance = distance;
    push_cmd.len      = len;
    push_cmd.status   = end_status;
    if (accept) begin
      if (in_word.kind == KIND_END) begin
        push          = 1'b1;
        push_cmd.kind = CMD_END;
      end else if (error_code == ST_NONE && produced < limit) begin
        case (phase)
          PH_ITEM: begin
            push = !cur_flag;
          end
          PH_HIGH: begin
            if (SIZE_BITS'(distance) <= produced && SIZE_BITS'(len) <= remaining) begin
              push          = 1'b1;
              push_cmd.kind = CMD_MATCH;
            end
          end
          default: begin
            push = 1'b0;
          end
        endcase
      end
    end
  end

  // parser state and configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_FLAG;
      flag_bits   <= '0;
      flag_pos    <= '0;
      token_low   <= '0;
      produced    <= '0;
      error_code  <= ST_NONE;
      byte_target <= '0;
    end else begin
      if (cfg_valid) begin
        byte_target <= cfg_data;
      end
      if (accept) begin
        if (in_word.kind == KIND_END) begin
          phase      <= PH_FLAG;
          flag_bits  <= '0;
          flag_pos   <= '0;
          token_low  <= '0;
          produced   <= '0;
          error_code <= ST_NONE;
        end else if (error_code == ST_NONE) begin
          if (produced >= limit) begin
            error_code <= ST_TRAIL;
          end else begin
            case (phase)
              PH_FLAG: begin
                flag_bits <= in_word.data_byte;
                flag_pos  <= '0;
                phase     <= PH_ITEM;
              end
              PH_ITEM: begin
                if (!cur_flag) begin
                  produced <= produced + SIZE_BITS'(1);
                  flag_pos <= flag_pos_inc;
                  phase    <= (flag_pos_inc == 3'd0) ? PH_FLAG : PH_ITEM;
                end else begin
                  token_low <= in_word.data_byte;
                  phase     <= PH_HIGH;
                end
              end
              PH_HIGH: begin
                if (SIZE_BITS'(distance) > produced) begin
                  error_code <= ST_DIST;
                end else if (SIZE_BITS'(len) > remaining) begin
                  error_code <= ST_OVER;
                end else begin
                  produced <= produced + SIZE_BITS'(len);
                  flag_pos <= flag_pos_inc;
                  phase    <= (flag_pos_inc == 3'd0) ? PH_FLAG : PH_ITEM;
                end
              end
              default: begin
                phase <= PH_FLAG;
              end
            endcase
          end
        end
      end
    end
  end

endmodule

FILE: src/lzfd_queue.sv
// two-entry command queue between parser and copy engine
module lzfd_queue import lzfd_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output logic empty,
  output cmd_t head
);

  localparam int DEPTH = 2;
  localparam int PW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);

  cmd_t          entries [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_push;
  logic          do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign head    = entries[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

FILE: src/lzfd_back.sv
// copy engine: history window, match copy and output register
module lzfd_back import lzfd_pkg::*; #(
  parameter int HISTORY_DEPTH = 8192
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      q_empty,
  input  cmd_t      q_head,
  output logic      pop,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_word
);

  localparam int PTR_W = $clog2(HISTORY_DEPTH);
  localparam int AW    = PTR_W + 2;

  typedef enum logic [1:0] {
    S_IDLE,
    S_FETCH,
    S_COPY
  } state_t;

  state_t           state;
  logic [PTR_W-1:0] ptr;
  logic [PTR_W-1:0] src;
  logic [LEN_W-1:0] cnt;

  logic [7:0]       window [HISTORY_DEPTH];
  logic [7:0]       rd_q;
  logic             byp_q;
  logic [7:0]       byp_d;

  logic             out_free;
  logic             advance;
  logic [PTR_W-1:0] ptr_inc;
  logic [PTR_W-1:0] src_inc;
  logic [PTR_W-1:0] src_start;
  logic [PTR_W-1:0] raddr;
  logic [7:0]       rdata;
  logic             we;
  logic [7:0]       wdata;
  logic             lit_go;
  logic             load;
  logic [AW-1:0]    ptr_x;
  logic [AW-1:0]    dist_x;

  function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] a);
    return (a == PTR_W'(HISTORY_DEPTH - 1)) ? '0 : a + PTR_W'(1);
  endfunction

  assign out_free = !out_valid || !out_stall;
  assign ptr_inc  = wrap_inc(ptr);
  assign src_inc  = wrap_inc(src);
  assign rdata    = byp_q ? byp_d : rd_q;
  assign advance  = (state == S_COPY) && out_free;

  // match start address, wrapped back into the window
  always_comb begin
    ptr_x     = AW'(ptr);
    dist_x    = AW'(q_head.distance);
    if (ptr_x >= dist_x) begin
      src_start = PTR_W'(ptr_x - dist_x);
    end else begin
      src_start = PTR_W'(ptr_x + AW'(HISTORY_DEPTH) - dist_x);
    end
  end

  // queue pop, memory write and read address
  always_comb begin
    pop    = 1'b0;
    lit_go = 1'b0;
    if (state == S_IDLE && !q_empty) begin
      case (q_head.kind)
        CMD_MATCH: pop = 1'b1;
        CMD_LIT: begin
          pop    = out_free;
          lit_go = out_free;
        end
        CMD_END: pop = out_free;
        default: pop = 1'b0;
      endcase
    end
    we    = lit_go || advance;
    wdata = lit_go ? q_head.data : rdata;
    raddr = advance ? src_inc : src;
    load  = lit_go || advance || (pop && q_head.kind == CMD_END);
  end

  // history window with a bypass for a read of the word being written
  always_ff @(posedge clk) begin
    if (we) begin
      window[ptr] <= wdata;
    end
    rd_q  <= window[raddr];
    byp_q <= we && (ptr == raddr);
    byp_d <= wdata;
  end

  // copy sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      ptr       <= '0;
      out_valid <= 1'b0;
    end else begin
      // output valid flag
      if (load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (pop) begin
            case (q_head.kind)
              CMD_LIT: begin
                out_word.out_byte   <= q_head.data;
                out_word.byte_valid <= 1'b1;
                out_word.status     <= ST_NONE;
                out_word.last       <= 1'b1;
                ptr                 <= ptr_inc;
              end
              CMD_MATCH: begin
                src   <= src_start;
                cnt   <= q_head.len;
                state <= S_FETCH;
              end
              CMD_END: begin
                out_word.out_byte   <= '0;
                out_word.byte_valid <= 1'b0;
                out_word.status     <= q_head.status;
                out_word.last       <= 1'b1;
                ptr                 <= '0;
              end
              default: begin
                state <= S_IDLE;
              end
            endcase
          end
        end
        S_FETCH: begin
          state <= S_COPY;
        end
        S_COPY: begin
          if (advance) begin
            out_word.out_byte   <= rdata;
            out_word.byte_valid <= 1'b1;
            out_word.status     <= ST_NONE;
            out_word.last       <= (cnt == LEN_W'(1));
            ptr                 <= ptr_inc;
            src                 <= src_inc;
            cnt                 <= cnt - LEN_W'(1);
            if (cnt == LEN_W'(1)) begin
              state <= S_IDLE;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: src/lzss_flag_byte_decompressor.sv
// top level of the flag-byte lzss decompressor
// Compressed bytes go in one word at a time; the parser takes a word every
// cycle while its two-entry command queue has room, flag bytes and first
// token bytes included, though these push no command. The copy engine behind
// the queue emits a literal as soon as its output register is free, and a
// match of 3 to 10 bytes in steps: it takes the token, reads the history
// memory, then emits one byte a cycle while the output is not stalled,
// through the single memory read port, with the word written in the
// previous cycle forwarded for overlapping matches. A match holds the copy
// engine until its last byte is out, so a stream of long matches fills the
// queue and stalls input. The end word returns one status word and restarts
// the block; the history memory is never cleared, as a match can only reach
// bytes written since the last restart. The output size register may be
// written only while the block is idle.
module lzss_flag_byte_decompressor import lzfd_pkg::*; #(
  parameter int HISTORY_DEPTH = 8192,
  parameter int SIZE_BITS     = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_word_t    in_word,
  output logic        out_valid,
  input  logic        out_stall,
  output out_word_t   out_word,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data
);

  logic push;
  cmd_t push_cmd;
  logic q_full;
  logic q_empty;
  logic pop;
  cmd_t q_head;

  // configuration writes are always taken
  assign cfg_ready = 1'b1;

  // parser
  lzfd_front #(
    .SIZE_BITS(SIZE_BITS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_word  (in_word),
    .cfg_valid(cfg_valid && cfg_ready),
    .cfg_data (cfg_data),
    .push     (push),
    .push_cmd (push_cmd),
    .q_full   (q_full)
  );

  // command queue
  lzfd_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_cmd(push_cmd),
    .full    (q_full),
    .pop     (pop),
    .empty   (q_empty),
    .head    (q_head)
  );

  // copy engine
  lzfd_back #(
    .HISTORY_DEPTH(HISTORY_DEPTH)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_empty  (q_empty),
    .q_head   (q_head),
    .pop      (pop),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_word (out_word)
  );

endmodule

FILE: bench/lzss_flag_byte_decompressor_checker.sv
// scoreboard that predicts and checks the decompressor's output words
module lzss_flag_byte_decompressor_checker import lzfd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  in_word_t    in_word,
  input  logic        out_valid,
  input  logic        out_stall,
  input  out_word_t   out_word,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [31:0] cfg_data,
  output int          mismatches,
  output int          due_count
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [1:0] {
    WANT_FLAG,
    WANT_ITEM,
    WANT_HIGH
  } parse_t;

  // predicted decoder state
  logic [31:0] size_limit;
  parse_t      phase;
  logic [7:0]  flags;
  logic [2:0]  flag_pos;
  logic [7:0]  token_lo;
  logic [31:0] produced;
  logic [7:0]  window [0:8191];
  logic [12:0] wr_ptr;
  logic [2:0]  fault;

  // words still owed by the block, oldest first
  out_word_t   due_words [$];
  out_word_t   held;
  bit          have_held;

  task automatic clear_parse();
    phase    = WANT_FLAG;
    flags    = '0;
    flag_pos = '0;
    token_lo = '0;
    produced = '0;
    wr_ptr   = '0;
    fault    = ST_NONE;
  endtask

  // the last word of a step is held back so its last bit can be set
  task automatic put_byte(input logic [7:0] value);
    window[wr_ptr] = value;
    wr_ptr   = wr_ptr + 1'b1;
    produced = produced + 1;
    if (have_held) due_words.push_back(held);
    held = '{out_byte: value, byte_valid: 1'b1, status: ST_NONE, last: 1'b0};
    have_held = 1'b1;
  endtask

  task automatic next_flag();
    flag_pos = flag_pos + 1'b1;
    phase    = (flag_pos == 3'd0) ? WANT_FLAG : WANT_ITEM;
  endtask

  task automatic decode_word(input in_word_t w);
    logic [15:0] token;
    logic [13:0] distance;
    logic [3:0]  len;
    logic [12:0] src;
    logic [2:0]  verdict;
    have_held = 1'b0;
    if (w.kind == KIND_END) begin
      // status word, then back to a fresh payload
      if (fault != ST_NONE) verdict = fault;
      else if (produced < size_limit) verdict = ST_SHORT;
      else verdict = ST_OK;
      held = '{out_byte: 8'h00, byte_valid: 1'b0, status: verdict, last: 1'b0};
      have_held = 1'b1;
      clear_parse();
    end else if (fault == ST_NONE) begin
      if (produced >= size_limit) begin
        fault = ST_TRAIL;
      end else begin
        case (phase)
          WANT_FLAG: begin
            flags    = w.data_byte;
            flag_pos = '0;
            phase    = WANT_ITEM;
          end
          WANT_ITEM: begin
            if (!flags[flag_pos]) begin
              put_byte(w.data_byte);
              next_flag();
            end else begin
              token_lo = w.data_byte;
              phase    = WANT_HIGH;
            end
          end
          default: begin
            // second token byte: distance check comes before length check
            token    = {w.data_byte, token_lo};
            distance = {1'b0, token[15:11], token[7:0]} + 14'd1;
            len      = {1'b0, token[10:8]} + {1'b0, MIN_MATCH};
            if (distance > produced) begin
              fault = ST_DIST;
            end else if (len > size_limit - produced) begin
              fault = ST_OVER;
            end else begin
              for (int i = 0; i < len; i++) begin
                src = wr_ptr - distance[12:0];
                put_byte(window[src]);
              end
              next_flag();
            end
          end
        endcase
      end
    end
    if (have_held) begin
      held.last = 1'b1;
      due_words.push_back(held);
    end
  endtask

  task automatic report(input string what, input out_word_t want, input out_word_t got);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t %s: expected byte %02h valid %0b status %0d last %0b",
               $time, what, want.out_byte, want.byte_valid, want.status, want.last,
               "   got byte %02h valid %0b status %0d last %0b",
               got.out_byte, got.byte_valid, got.status, got.last);
  endtask

  // predict on input words, compare on output words
  always @(posedge clk) begin
    out_word_t want;
    if (rst) begin
      size_limit = '0;
      clear_parse();
      due_words.delete();
      have_held  = 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) size_limit = cfg_data;
      if (in_valid && !in_stall) decode_word(in_word);
      if (out_valid && !out_stall) begin
        if (due_words.size() == 0) begin
          report("unexpected word, nothing due", '0, out_word);
        end else begin
          want = due_words.pop_front();
          if (out_word.out_byte !== want.out_byte || out_word.byte_valid !== want.byte_valid ||
              out_word.status !== want.status || out_word.last !== want.last)
            report("mismatch", want, out_word);
        end
      end
    end
    due_count = due_words.size();
  end

endmodule

FILE: bench/lzss_flag_byte_decompressor_tb.sv
// testbench top: stimulus, idling and verdict for the flag-byte lzss decompressor
module lzss_flag_byte_decompressor_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import lzfd_pkg::*;

  typedef enum {
    SHAPE_CLEAN,
    SHAPE_SHORT,
    SHAPE_TRAIL,
    SHAPE_FAR,
    SHAPE_OVERRUN,
    SHAPE_NOISE
  } shape_t;

  localparam int SETTLE_CYCLES = 24;
  localparam int RANDOM_ITEMS  = 115;

  logic        clk = 1'b0;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  in_word_t    in_word;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_word_t   out_word;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [31:0] cfg_data;
  int          mismatches;
  int          due_count;

  int          send_idle;
  int          recv_idle;
  logic [7:0]  stream_bytes [$];

  always #4 clk = ~clk;

  lzss_flag_byte_decompressor dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  lzss_flag_byte_decompressor_checker watch (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_word    (in_word),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_word   (out_word),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .mismatches (mismatches),
    .due_count  (due_count)
  );

  // receiver back-pressure
  always @(negedge clk) begin
    out_stall <= ($urandom_range(0, 99) < recv_idle);
  end

  // one input word, with random idle cycles ahead of it
  task automatic push_word(input logic kind, input logic [7:0] value);
    while ($urandom_range(0, 99) < send_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= '{kind: kind, data_byte: value};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  // stop sending until every predicted word has come out
  task automatic hold_until_empty(input int settle);
    in_valid <= 1'b0;
    do @(negedge clk); while (due_count != 0);
    repeat (settle) @(negedge clk);
  endtask

  task automatic set_byte_target(input logic [31:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // size write while idle, the compressed bytes, then the end word
  task automatic send_payload(input logic [31:0] size);
    hold_until_empty(SETTLE_CYCLES);
    set_byte_target(size);
    foreach (stream_bytes[i]) begin
      if ($urandom_range(0, 39) == 0) hold_until_empty(0);
      push_word(KIND_BYTE, stream_bytes[i]);
    end
    push_word(KIND_END, 8'($urandom_range(0, 255)));
  endtask

  // well-formed compressed stream for target bytes, with an optional flaw
  task automatic build_stream(input int unsigned target, input shape_t shape);
    logic [7:0]  flags;
    logic [7:0]  group [$];
    logic [12:0] span;
    int unsigned made;
    int unsigned room;
    int unsigned len;
    int unsigned plant_at;
    int unsigned keep;
    bit          planted;
    stream_bytes.delete();
    made     = 0;
    planted  = 1'b0;
    plant_at = $urandom_range(0, target);
    if (shape == SHAPE_NOISE) begin
      repeat ($urandom_range(1, 12)) stream_bytes.push_back(8'($urandom_range(0, 255)));
      return;
    end
    while (made < target) begin
      flags = '0;
      group.delete();
      for (int b = 0; b < 8; b++) begin
        room = target - made;
        if (made >= target) begin
          // flag bits past the end are ignored
          flags[b] = 1'($urandom_range(0, 1));
        end else if (!planted && shape == SHAPE_FAR && made >= plant_at) begin
          // distance beyond everything produced so far
          span = 13'($urandom_range(made, 8191));
          flags[b] = 1'b1;
          group.push_back(span[7:0]);
          group.push_back({span[12:8], 3'($urandom_range(0, 7))});
          planted    = 1'b1;
        end else if (!planted && shape == SHAPE_OVERRUN && made >= 1 && room <= 9) begin
          // match longer than the bytes still expected
          len  = $urandom_range(room + 1, 10);
          span = 13'($urandom_range(0, made - 1));
          flags[b] = 1'b1;
          group.push_back(span[7:0]);
          group.push_back({span[12:8], 3'(len - 3)});
          planted    = 1'b1;
        end else if (made >= 1 && room >= 3 && $urandom_range(0, 1) == 1) begin
          // valid match, mostly short distances so overlaps are common
          len  = $urandom_range(3, (room < 10) ? room : 10);
          span = 13'($urandom_range(0, ($urandom_range(0, 1) == 1 && made > 16) ? 15 : made - 1));
          flags[b] = 1'b1;
          group.push_back(span[7:0]);
          group.push_back({span[12:8], 3'(len - 3)});
          made += len;
        end else begin
          group.push_back(8'($urandom_range(0, 255)));
          made++;
        end
      end
      stream_bytes.push_back(flags);
      foreach (group[i]) stream_bytes.push_back(group[i]);
    end
    if (shape == SHAPE_SHORT && stream_bytes.size() > 0) begin
      keep = $urandom_range(0, stream_bytes.size() - 1);
      while (stream_bytes.size() > keep) void'(stream_bytes.pop_back());
    end else if (shape == SHAPE_TRAIL) begin
      repeat ($urandom_range(1, 3)) stream_bytes.push_back(8'($urandom_range(0, 255)));
    end
  endtask

  // stimulus and verdict
  initial begin
    int          sent;
    int          pick;
    int          budget;
    logic [31:0] size;
    int unsigned target;
    shape_t      shape;
    rst       = 1'b1;
    in_valid  = 1'b0;
    in_word   = '0;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    send_idle = 29;
    recv_idle = 56;
    repeat (10) @(negedge clk);
    rst <= 1'b0;

    // empty payload of size zero
    stream_bytes.delete();
    send_payload(32'd0);
    // byte after completion
    stream_bytes = '{8'h5a};
    send_payload(32'd0);
    // literals at the byte extremes
    stream_bytes = '{8'h00, 8'h00, 8'hff};
    send_payload(32'd2);
    // overlapping match, then leftover flag bits
    stream_bytes = '{8'h02, 8'h11, 8'h00, 8'h07, 8'h22, 8'h33};
    send_payload(32'd13);
    // distance too far, which also overruns: distance wins
    stream_bytes = '{8'h01, 8'hff, 8'hff};
    send_payload(32'd3);
    // match overruns, then a dropped byte
    stream_bytes = '{8'h02, 8'h7e, 8'h00, 8'h07, 8'h33};
    send_payload(32'd5);
    // payload short of the largest size
    stream_bytes = '{8'h00, 8'h80};
    send_payload(32'hffff_ffff);

    // random payloads under three idling settings
    for (int ph = 0; ph < 3; ph++) begin
      send_idle = (ph == 0) ? 29 : (ph == 1) ? 56 : 0;
      recv_idle = (ph == 0) ? 56 : (ph == 1) ? 29 : 0;
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
        budget = RANDOM_ITEMS - sent;
        pick = $urandom_range(0, 99);
        if (pick < 8) begin
          size   = 32'd0;
          target = 0;
        end else if (pick < 14) begin
          size   = pick[0] ? 32'hffff_ffff : ($urandom() | 32'h0010_0000);
          target = $urandom_range(1, 30);
        end else if (pick < 20) begin
          size   = $urandom_range(100, 300);
          target = size;
        end else begin
          size   = $urandom_range(1, 40);
          target = size;
        end
        // keep the target size of a payload within the word budget
        if (pick >= 14 && target > budget) begin
          target = budget;
          size   = 32'(budget);
        end
        pick = $urandom_range(0, 99);
        if (pick < 50) shape = SHAPE_CLEAN;
        else if (pick < 60) shape = SHAPE_SHORT;
        else if (pick < 70) shape = SHAPE_TRAIL;
        else if (pick < 80) shape = SHAPE_FAR;
        else if (pick < 90) shape = SHAPE_OVERRUN;
        else shape = SHAPE_NOISE;
        build_stream(target, shape);
        send_payload(size);
        sent += stream_bytes.size() + 1;
      end
    end

    hold_until_empty(SETTLE_CYCLES);
    if (mismatches == 0 && due_count == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

  // watchdog
  initial begin
    #4_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule
